@@ sv/wer_pkg.sv @@
// ----------------------------------------------------------------------------
// wer_pkg
// Shared types and constants of the wireframe edge rasteriser.
// ----------------------------------------------------------------------------
`default_nettype none

package wer_pkg;

  localparam int ZOOM_W     = 6;
  localparam int SHIFT_W    = 11;
  localparam int Z_W        = 5;
  localparam int PIX_W      = 17;
  localparam int COLOUR_W   = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Isometric coefficients cos(0.8) and sin(0.8) in Q20, rounded to nearest
  localparam int COEF_FRAC = 20;
  localparam int COS_Q20   = 730550;
  localparam int SIN_Q20   = 752202;

  localparam logic [COLOUR_W-1:0] RED_COLOUR   = 24'he80c0c;
  localparam logic [COLOUR_W-1:0] WHITE_COLOUR = 24'hffffff;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZOOM     = 2'd0,
    CFG_SHIFT_X  = 2'd1,
    CFG_SHIFT_Y  = 2'd2,
    CFG_PROJ_OFF = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic load;
    logic scale;
    logic proj;
    logic place;
    logic delta;
    logic absval;
    logic max;
    logic div_start;
    logic walk_init;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic short_edge;
    logic div_busy;
    logic can_emit;
    logic last;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ sv/wireframe_edge_rasterizer.sv @@
// ----------------------------------------------------------------------------
// wireframe_edge_rasterizer
// Projects one height-map grid edge and walks it as a DDA line, one pixel a
// transaction.
// ----------------------------------------------------------------------------
// One edge at a time: after the accepting cycle the setup steps (grid scaling,
// projection multiply, placement, delta, magnitude, maximum, length check)
// run in order, the two step divisions then run side by side up to the step
// load, and the walk then delivers one pixel a cycle while the output is not
// stalled, up to MAX_PIXELS pixels. An edge shorter than one pixel is dropped
// after the length check and gives no pixel. The shift-subtract divider sets
// the setup time.
// ----------------------------------------------------------------------------
`default_nettype none

module wireframe_edge_rasterizer
  import wer_pkg::*;
#(
  parameter int GRID_BITS  = 10,
  parameter int FRAC_BITS  = 16,
  parameter int MAX_PIXELS = 64
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_valid,
  output      logic                    cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                    valid_i,
  output      logic                    stall_o,
  input  wire logic [GRID_BITS-1:0]    col_i,
  input  wire logic [GRID_BITS-1:0]    row_i,
  input  wire logic                    dir_i,
  input  wire logic signed [Z_W-1:0]   z_start_i,
  input  wire logic signed [Z_W-1:0]   z_end_i,
  output      logic                    valid_o,
  input  wire logic                    stall_i,
  output      logic signed [PIX_W-1:0] px_o,
  output      logic signed [PIX_W-1:0] py_o,
  output      logic [COLOUR_W-1:0]     colour_o,
  output      logic                    last_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  wer_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (valid_i),
    .in_stall_o (stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wer_dp #(
    .GRID_BITS  (GRID_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .MAX_PIXELS (MAX_PIXELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid && cfg_ready),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .col_i       (col_i),
    .row_i       (row_i),
    .dir_i       (dir_i),
    .z_start_i   (z_start_i),
    .z_end_i     (z_end_i),
    .out_stall_i (stall_i),
    .out_valid_o (valid_o),
    .px_o        (px_o),
    .py_o        (py_o),
    .colour_o    (colour_o),
    .last_o      (last_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  a_accept_locks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o |=> stall_o)
    else $error("edge accepted but input not held off");

  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> stall_o)
    else $error("pixel emitted while input open");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit && sts.last |=> !stall_o)
    else $error("input not reopened after last pixel");

  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> sts.div_busy)
    else $error("divider did not start");

endmodule

`default_nettype wire

@@ sv/wer_div.sv @@
// ----------------------------------------------------------------------------
// wer_div
// Restoring divider: (dividend * 2^(QW-2)) / divisor, one quotient bit a cycle,
// truncated toward zero. Requires |dividend| <= divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module wer_div #(
  parameter int W  = 37,
  parameter int QW = 18
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic signed [W-1:0] dividend_i,
  input  wire logic        [W-1:0] divisor_i,
  output      logic                busy_o,
  output      logic signed [QW-1:0] quo_o
);

  localparam int CNT_W = $clog2(QW);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [W:0]       rem_q, rem_d;
  logic [QW-2:0]    quo_q, quo_d;
  logic [W-1:0]     den_q, den_d;
  logic             neg_q, neg_d;
  logic             ge;
  logic [W:0]       diff;
  logic [W-1:0]     mag;

  always_comb begin
    mag    = dividend_i[W-1] ? W'(-dividend_i) : W'(dividend_i);
    ge     = rem_q >= {1'b0, den_q};
    diff   = ge ? rem_q - {1'b0, den_q} : rem_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(QW - 1);
      rem_d  = {1'b0, mag};
      quo_d  = '0;
      den_d  = divisor_i;
      neg_d  = dividend_i[W-1];
    end else if (busy_q) begin
      rem_d = {diff[W-1:0], 1'b0};
      quo_d = {quo_q[QW-3:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

`default_nettype wire

@@ sv/wer_dp.sv @@
// ----------------------------------------------------------------------------
// wer_dp
// Datapath: configuration, projection, line setup, step division and DDA walk
// with the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wer_dp
  import wer_pkg::*;
#(
  parameter int GRID_BITS  = 10,
  parameter int FRAC_BITS  = 16,
  parameter int MAX_PIXELS = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]       cfg_data_i,
  input  wire logic [GRID_BITS-1:0]        col_i,
  input  wire logic [GRID_BITS-1:0]        row_i,
  input  wire logic                        dir_i,
  input  wire logic signed [Z_W-1:0]       z_start_i,
  input  wire logic signed [Z_W-1:0]       z_end_i,
  input  wire logic                        out_stall_i,
  output      logic                        out_valid_o,
  output      logic signed [PIX_W-1:0]     px_o,
  output      logic signed [PIX_W-1:0]     py_o,
  output      logic [COLOUR_W-1:0]         colour_o,
  output      logic                        last_o,
  input  wire dp_cmd_t                     cmd_i,
  output      dp_sts_t                     sts_o
);

  localparam int GX_W  = GRID_BITS + ZOOM_W + 1;
  localparam int DF_W  = GX_W + 1;
  localparam int CF_W  = FRAC_BITS + 1;
  localparam int PR_W  = DF_W + CF_W;
  localparam int W     = GX_W + FRAC_BITS + 4;
  localparam int QW    = FRAC_BITS + 2;
  localparam int PC_W  = $clog2(MAX_PIXELS);
  localparam int CSH   = COEF_FRAC - FRAC_BITS;
  localparam int COS_I = (COS_Q20 + ((1 << CSH) >> 1)) >> CSH;
  localparam int SIN_I = (SIN_Q20 + ((1 << CSH) >> 1)) >> CSH;
  localparam logic signed [CF_W-1:0] COS_C = CF_W'(COS_I);
  localparam logic signed [CF_W-1:0] SIN_C = CF_W'(SIN_I);
  localparam logic signed [W-1:0] ONE =
    {{(W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [W-1:0] NEG_ONE = -ONE;

  function automatic logic signed [W-1:0] to_q(input logic signed [W-1:0] v);
    return v <<< FRAC_BITS;
  endfunction

  // truncate toward zero, wrap to pixel width
  function automatic logic signed [PIX_W-1:0] trunc_q(input logic signed [W-1:0] v);
    logic signed [W-1:0] sh;
    logic                adj;
    sh  = v >>> FRAC_BITS;
    adj = v[W-1] && (v[FRAC_BITS-1:0] != '0);
    return PIX_W'(sh + W'(adj));
  endfunction

  function automatic logic cont(input logic signed [W-1:0] v);
    return (v >= ONE) || (v <= NEG_ONE);
  endfunction

  // configuration
  logic [ZOOM_W-1:0]         zoom_q;
  logic signed [SHIFT_W-1:0] shift_x_q, shift_y_q;
  logic                      proj_off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zoom_q     <= ZOOM_W'(1);
      shift_x_q  <= '0;
      shift_y_q  <= '0;
      proj_off_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ZOOM:     zoom_q     <= cfg_data_i[ZOOM_W-1:0];
        CFG_SHIFT_X:  shift_x_q  <= $signed(cfg_data_i[SHIFT_W-1:0]);
        CFG_SHIFT_Y:  shift_y_q  <= $signed(cfg_data_i[SHIFT_W-1:0]);
        CFG_PROJ_OFF: proj_off_q <= cfg_data_i[0];
        default:      zoom_q     <= zoom_q;
      endcase
    end
  end

  // edge registers
  logic [GRID_BITS-1:0]    col_q, row_q;
  logic                    dir_q;
  logic signed [Z_W-1:0]   z0_q, z1_q;
  logic [COLOUR_W-1:0]     edge_colour_q;
  logic [GX_W-1:0]         gx0_q, gy0_q, gx1_q, gy1_q;
  logic signed [PR_W-1:0]  prx0_q, pry0_q, prx1_q, pry1_q;
  logic signed [DF_W-1:0]  dfx0, sfy0, dfx1, sfy1;
  logic signed [W-1:0]     cur_x_q, cur_y_q, end_x_q, end_y_q;
  logic signed [W-1:0]     dx_q, dy_q, adx_q, ady_q, mx_q;
  logic signed [W-1:0]     rem_x_q, rem_y_q, remn_x_q, remn_y_q;
  logic signed [QW-1:0]    step_x_q, step_y_q;
  logic [PC_W-1:0]         cnt_q;
  logic signed [PIX_W-1:0] px_q, py_q;
  logic [COLOUR_W-1:0]     colour_q;
  logic                    last_q, out_valid_q, last;
  logic signed [QW-1:0]    quo_x, quo_y;
  logic                    busy_x, busy_y;

  assign dfx0 = $signed({1'b0, gx0_q}) - $signed({1'b0, gy0_q});
  assign sfy0 = $signed({1'b0, gx0_q}) + $signed({1'b0, gy0_q});
  assign dfx1 = $signed({1'b0, gx1_q}) - $signed({1'b0, gy1_q});
  assign sfy1 = $signed({1'b0, gx1_q}) + $signed({1'b0, gy1_q});

  assign last = (cnt_q == PC_W'(MAX_PIXELS - 1)) || !(cont(remn_x_q) || cont(remn_y_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      col_q         <= col_i;
      row_q         <= row_i;
      dir_q         <= dir_i;
      z0_q          <= z_start_i;
      z1_q          <= z_end_i;
      edge_colour_q <= (z_start_i != '0 || z_end_i != '0) ? RED_COLOUR : WHITE_COLOUR;
    end
    if (cmd_i.scale) begin
      gx0_q <= GX_W'(col_q) * GX_W'(zoom_q);
      gy0_q <= GX_W'(row_q) * GX_W'(zoom_q);
      gx1_q <= (GX_W'(col_q) + GX_W'(!dir_q)) * GX_W'(zoom_q);
      gy1_q <= (GX_W'(row_q) + GX_W'(dir_q)) * GX_W'(zoom_q);
    end
    if (cmd_i.proj) begin
      prx0_q <= dfx0 * COS_C;
      pry0_q <= sfy0 * SIN_C;
      prx1_q <= dfx1 * COS_C;
      pry1_q <= sfy1 * SIN_C;
    end
    if (cmd_i.place) begin
      cur_x_q <= (proj_off_q ? to_q(W'($signed({1'b0, gx0_q}))) : W'(prx0_q))
                 + to_q(W'(shift_x_q));
      cur_y_q <= (proj_off_q ? to_q(W'($signed({1'b0, gy0_q})))
                             : W'(pry0_q) - to_q(W'(z0_q)))
                 + to_q(W'(shift_y_q));
      end_x_q <= (proj_off_q ? to_q(W'($signed({1'b0, gx1_q}))) : W'(prx1_q))
                 + to_q(W'(shift_x_q));
      end_y_q <= (proj_off_q ? to_q(W'($signed({1'b0, gy1_q})))
                             : W'(pry1_q) - to_q(W'(z1_q)))
                 + to_q(W'(shift_y_q));
    end
    if (cmd_i.delta) begin
      dx_q    <= end_x_q - cur_x_q;
      dy_q    <= end_y_q - cur_y_q;
      rem_x_q <= cur_x_q - end_x_q;
      rem_y_q <= cur_y_q - end_y_q;
    end
    if (cmd_i.absval) begin
      adx_q <= dx_q[W-1] ? -dx_q : dx_q;
      ady_q <= dy_q[W-1] ? -dy_q : dy_q;
    end
    if (cmd_i.max) begin
      mx_q <= (adx_q > ady_q) ? adx_q : ady_q;
    end
    if (cmd_i.walk_init) begin
      step_x_q <= quo_x;
      step_y_q <= quo_y;
      remn_x_q <= rem_x_q + W'(quo_x);
      remn_y_q <= rem_y_q + W'(quo_y);
      cnt_q    <= '0;
    end
    if (cmd_i.emit) begin
      px_q     <= trunc_q(cur_x_q);
      py_q     <= trunc_q(cur_y_q);
      colour_q <= edge_colour_q;
      last_q   <= last;
      cur_x_q  <= cur_x_q + W'(step_x_q);
      cur_y_q  <= cur_y_q + W'(step_y_q);
      rem_x_q  <= remn_x_q;
      rem_y_q  <= remn_y_q;
      remn_x_q <= remn_x_q + W'(step_x_q);
      remn_y_q <= remn_y_q + W'(step_y_q);
      cnt_q    <= cnt_q + PC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  wer_div #(.W(W), .QW(QW)) u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dx_q),
    .divisor_i  ($unsigned(mx_q)),
    .busy_o     (busy_x),
    .quo_o      (quo_x)
  );

  wer_div #(.W(W), .QW(QW)) u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dy_q),
    .divisor_i  ($unsigned(mx_q)),
    .busy_o     (busy_y),
    .quo_o      (quo_y)
  );

  assign sts_o.short_edge = mx_q < ONE;
  assign sts_o.div_busy   = busy_x || busy_y;
  assign sts_o.can_emit   = !out_valid_q || !out_stall_i;
  assign sts_o.last       = last;

  assign out_valid_o = out_valid_q;
  assign px_o        = px_q;
  assign py_o        = py_q;
  assign colour_o    = colour_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

@@ sv/wer_ctrl.sv @@
// ----------------------------------------------------------------------------
// wer_ctrl
// Sequencer: steps one edge through setup, division and the pixel walk.
// ----------------------------------------------------------------------------
`default_nettype none

module wer_ctrl
  import wer_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output      logic    in_stall_o,
  input  wire dp_sts_t sts_i,
  output      dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCALE, ST_PROJ, ST_PLACE, ST_DELTA, ST_ABS, ST_MAX, ST_CHECK,
    ST_DIV, ST_WALK
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_PROJ;
      end
      ST_PROJ: begin
        cmd_o.proj = 1'b1;
        state_d    = ST_PLACE;
      end
      ST_PLACE: begin
        cmd_o.place = 1'b1;
        state_d     = ST_DELTA;
      end
      ST_DELTA: begin
        cmd_o.delta = 1'b1;
        state_d     = ST_ABS;
      end
      ST_ABS: begin
        cmd_o.absval = 1'b1;
        state_d      = ST_MAX;
      end
      ST_MAX: begin
        cmd_o.max = 1'b1;
        state_d   = ST_CHECK;
      end
      ST_CHECK: begin
        // drop edges shorter than one pixel
        if (sts_i.short_edge) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!sts_i.div_busy) begin
          cmd_o.walk_init = 1'b1;
          state_d         = ST_WALK;
        end
      end
      ST_WALK: begin
        if (sts_i.can_emit) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != ST_IDLE;

endmodule

`default_nettype wire
